FILE: hdl/heart_rate_anomaly_detector_unit_defines.svh
// ----------------------------------------------------------------------------
// Heart-rate anomaly detector: assertion macros
// Property wrappers for the checker file of the detector.
// ----------------------------------------------------------------------------
`ifndef HEART_RATE_ANOMALY_DETECTOR_UNIT_DEFINES_SVH
`define HEART_RATE_ANOMALY_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication, switched off while reset is high
`define HRAD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrad check failed");

// next-cycle implication, switched off while reset is high
`define HRAD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrad check failed");

`endif

FILE: hdl/hrad_pkg.sv
// ----------------------------------------------------------------------------
// hrad_pkg
// Types and fixed constants shared by the heart-rate anomaly detector.
// ----------------------------------------------------------------------------
`default_nettype none

package hrad_pkg;

   // field widths
   localparam int BPM_W   = 8;
   localparam int TS_W    = 48;
   localparam int EVT_W   = 2;
   localparam int TACHY_W = 8;
   localparam int BRADY_W = 7;
   localparam int PERS_W  = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // quotient of the mean is at most 250, so eight quotient bits
   localparam int QUO_W  = 8;
   localparam int STEP_W = 3;

   // sample sanity limit
   localparam logic [BPM_W-1:0] BPM_MAX = 8'd250;

   // threshold write limits
   localparam logic [TACHY_W-1:0] TACHY_LOW  = 8'd80;
   localparam logic [TACHY_W-1:0] TACHY_HIGH = 8'd220;
   localparam logic [BRADY_W-1:0] BRADY_LOW  = 7'd20;
   localparam logic [BRADY_W-1:0] BRADY_HIGH = 7'd80;

   // register reset values
   localparam logic [TACHY_W-1:0] TACHY_RESET = 8'd120;
   localparam logic [BRADY_W-1:0] BRADY_RESET = 7'd45;
   localparam logic [PERS_W-1:0]  PERS_RESET  = 16'd3000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TACHY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRADY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSIST = 2'd2;

   // event codes
   localparam logic [EVT_W-1:0] EVT_NONE = 2'd0;
   localparam logic [EVT_W-1:0] EVT_FAST = 2'd1;
   localparam logic [EVT_W-1:0] EVT_SLOW = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_EVAL,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic              capture;   // take the incoming item
      logic              update;    // ring and sum update, divider load
      logic              skip;      // ignored sample: hold the last mean
      logic              div_step;  // one restoring division step
      logic [STEP_W-1:0] step;      // quotient bit being decided
      logic              eval;      // episode tracking and event
      logic              load_out;  // move result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sample_ok;
   } status_type;

endpackage

`default_nettype wire

FILE: hdl/heart_rate_anomaly_detector_unit.sv
// ----------------------------------------------------------------------------
// heart_rate_anomaly_detector_unit
// Moving-average heart-rate filter with fast and slow rate episode tracking.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_bpm, req_timestamp_ms
//   rsp      out        rsp_valid/rsp_ready   rsp_event_res, rsp_filtered_bpm
//   csr      in         csr_we                csr_index, csr_wdata
//
// A valid sample passes from acceptance to a loaded result through a ring
// update, the restoring divider (one mean bit per cycle), an evaluation
// and the load of the output register; an ignored sample skips the divider
// and the evaluation. The next item is accepted once back in the idle state.
// Synchronous reset restores the thresholds and empties the window.
// A stalled result waits in the output register; the block only holds in
// its final state when a new result finds that register still occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module heart_rate_anomaly_detector_unit import hrad_pkg::*; #(
   parameter int WINDOW = 5
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [BPM_W-1:0]     req_bpm,
   input  wire logic [TS_W-1:0]      req_timestamp_ms,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [EVT_W-1:0]          rsp_event_res,
   output logic [BPM_W-1:0]          rsp_filtered_bpm,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   hrad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hrad_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_bpm          (req_bpm),
      .req_timestamp_ms (req_timestamp_ms),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_event_res    (rsp_event_res),
      .rsp_filtered_bpm (rsp_filtered_bpm)
   );

endmodule

`default_nettype wire

FILE: hdl/hrad_ctrl.sv
// ----------------------------------------------------------------------------
// hrad_ctrl
// Sequencer for the detector: accepts an item, steps the datapath through
// update, division and evaluation, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module hrad_ctrl import hrad_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;

   // output register can take a result this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.sample_ok ? ST_DIVIDE : ST_FINISH;
         end
         ST_DIVIDE: begin
            if (step_ff == '0) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      cmd.step  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_CHECK: begin
            cmd.update = status.sample_ok;
            cmd.skip   = !status.sample_ok;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
         end
         ST_FINISH: begin
            cmd.load_out = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // quotient bit counter, high bit first
   always_comb begin
      step_in = step_ff;
      if (state_ff == ST_CHECK) begin
         step_in = STEP_W'(QUO_W - 1);
      end else if (state_ff == ST_DIVIDE && step_ff != '0) begin
         step_in = step_ff - 1'b1;
      end
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hdl/hrad_datapath.sv
// ----------------------------------------------------------------------------
// hrad_datapath
// Sample ring, running sum, restoring divider for the mean, episode
// tracking against the thresholds and the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module hrad_datapath import hrad_pkg::*; #(
   parameter int WINDOW = 5
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   output status_type                status,
   input  wire logic [BPM_W-1:0]     req_bpm,
   input  wire logic [TS_W-1:0]      req_timestamp_ms,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata,
   output logic [EVT_W-1:0]          rsp_event_res,
   output logic [BPM_W-1:0]          rsp_filtered_bpm
);

   localparam int SUM_W  = $clog2(int'(BPM_MAX) * WINDOW + 1);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   // configuration
   logic [TACHY_W-1:0] tachy_ff;
   logic [BRADY_W-1:0] brady_ff;
   logic [PERS_W-1:0]  persist_ff;
   logic [TACHY_W-1:0] csr_tachy;
   logic [BRADY_W-1:0] csr_brady;

   // item being worked on
   logic [BPM_W-1:0] bpm_ff;
   logic [TS_W-1:0]  ts_ff;

   // ring and running sum
   logic [BPM_W-1:0]  win_mem [WINDOW];
   logic [BPM_W-1:0]  rd_ff;
   logic [PTR_W-1:0]  wpos_ff, wpos_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              full;

   // divider
   logic [SUM_W-1:0] rem_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [SUM_W-1:0] trial;
   logic             take;

   // episodes
   logic [BPM_W-1:0] avg_ff;
   logic             fast_ep_ff, fast_ep_in;
   logic             slow_ep_ff, slow_ep_in;
   logic [TS_W-1:0]  fast_start_ff, fast_start_in;
   logic [TS_W-1:0]  slow_start_ff, slow_start_in;
   logic [TS_W:0]    fast_diff, slow_diff;
   logic             fast_fire, slow_fire;
   logic [EVT_W-1:0] event_in;

   // pending and output result
   logic [EVT_W-1:0] pend_evt_ff;
   logic [BPM_W-1:0] pend_avg_ff;
   logic [EVT_W-1:0] out_evt_ff;
   logic [BPM_W-1:0] out_avg_ff;

   assign status.sample_ok = (bpm_ff != '0) && (bpm_ff <= BPM_MAX);

   // configuration writes, out-of-range thresholds dropped
   assign csr_tachy = csr_wdata[TACHY_W-1:0];
   assign csr_brady = csr_wdata[BRADY_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         tachy_ff   <= TACHY_RESET;
         brady_ff   <= BRADY_RESET;
         persist_ff <= PERS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TACHY: begin
               if (csr_tachy >= TACHY_LOW && csr_tachy <= TACHY_HIGH) tachy_ff <= csr_tachy;
            end
            CSR_BRADY: begin
               if (csr_brady >= BRADY_LOW && csr_brady <= BRADY_HIGH) brady_ff <= csr_brady;
            end
            CSR_PERSIST: begin
               persist_ff <= csr_wdata[PERS_W-1:0];
            end
            default: begin
               persist_ff <= persist_ff;
            end
         endcase
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         bpm_ff <= req_bpm;
         ts_ff  <= req_timestamp_ms;
      end
   end

   // ring memory: the slot about to be overwritten is read ahead of time
   always_ff @(posedge clock) begin
      if (cmd.update) win_mem[wpos_ff] <= bpm_ff;
      rd_ff <= win_mem[wpos_ff];
   end

   // ring update: the oldest sample leaves the sum once the window is full
   assign full = (fill_ff == FILL_W'(WINDOW));

   always_comb begin
      sum_in  = sum_ff - (full ? SUM_W'(rd_ff) : '0) + SUM_W'(bpm_ff);
      wpos_in = (wpos_ff == PTR_W'(WINDOW - 1)) ? '0 : wpos_ff + 1'b1;
      fill_in = full ? fill_ff : fill_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         wpos_ff <= '0;
         fill_ff <= '0;
      end else if (cmd.update) begin
         sum_ff  <= sum_in;
         wpos_ff <= wpos_in;
         fill_ff <= fill_in;
      end
   end

   // restoring divider, one quotient bit per cycle
   assign trial = SUM_W'(fill_ff) << cmd.step;
   assign take  = (rem_ff >= trial);

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rem_ff <= sum_in;
         quo_ff <= '0;
      end else if (cmd.div_step && take) begin
         rem_ff           <= rem_ff - trial;
         quo_ff[cmd.step] <= 1'b1;
      end
   end

   // episode tracking on the new mean
   always_comb begin
      if (quo_ff >= tachy_ff) begin
         fast_ep_in    = 1'b1;
         fast_start_in = fast_ep_ff ? fast_start_ff : ts_ff;
      end else begin
         fast_ep_in    = 1'b0;
         fast_start_in = '0;
      end
      if (quo_ff <= {1'b0, brady_ff}) begin
         slow_ep_in    = 1'b1;
         slow_start_in = slow_ep_ff ? slow_start_ff : ts_ff;
      end else begin
         slow_ep_in    = 1'b0;
         slow_start_in = '0;
      end
   end

   // persistence: signed elapsed time against persist_ms
   assign fast_diff = {1'b0, ts_ff} - {1'b0, fast_start_in};
   assign slow_diff = {1'b0, ts_ff} - {1'b0, slow_start_in};
   assign fast_fire = fast_ep_in && (fast_start_in != '0) && !fast_diff[TS_W]
                      && (fast_diff[TS_W-1:0] >= TS_W'(persist_ff));
   assign slow_fire = slow_ep_in && (slow_start_in != '0) && !slow_diff[TS_W]
                      && (slow_diff[TS_W-1:0] >= TS_W'(persist_ff));

   always_comb begin
      if (fast_fire) begin
         event_in = EVT_FAST;
      end else if (slow_fire) begin
         event_in = EVT_SLOW;
      end else begin
         event_in = EVT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff        <= '0;
         fast_ep_ff    <= 1'b0;
         slow_ep_ff    <= 1'b0;
         fast_start_ff <= '0;
         slow_start_ff <= '0;
      end else if (cmd.eval) begin
         avg_ff        <= quo_ff;
         fast_ep_ff    <= fast_ep_in;
         slow_ep_ff    <= slow_ep_in;
         fast_start_ff <= fast_start_in;
         slow_start_ff <= slow_start_in;
      end
   end

   // pending result: ignored samples repeat the held mean
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         pend_evt_ff <= event_in;
         pend_avg_ff <= quo_ff;
      end else if (cmd.skip) begin
         pend_evt_ff <= EVT_NONE;
         pend_avg_ff <= avg_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_evt_ff <= pend_evt_ff;
         out_avg_ff <= pend_avg_ff;
      end
   end

   assign rsp_event_res    = out_evt_ff;
   assign rsp_filtered_bpm = out_avg_ff;

endmodule

`default_nettype wire

FILE: hdl/hrad_checker.sv
// ----------------------------------------------------------------------------
// hrad_checker
// Port-level checks on the detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "heart_rate_anomaly_detector_unit_defines.svh"

module hrad_checker import hrad_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [EVT_W-1:0] rsp_event_res,
   input wire logic [BPM_W-1:0] rsp_filtered_bpm
);

   // a stalled result holds its payload
   `HRAD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_res) && $stable(rsp_filtered_bpm))

   // one item at a time: no acceptance in the cycle after one
   `HRAD_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

   // a fast-rate event needs a mean at or above the lowest tachy threshold
   `HRAD_ASSERT_NOW(a_fast_mean, clock, reset, rsp_valid && rsp_event_res == EVT_FAST, rsp_filtered_bpm >= TACHY_LOW)

   // a slow-rate event needs a nonzero mean at or below the highest brady threshold
   `HRAD_ASSERT_NOW(a_slow_mean, clock, reset, rsp_valid && rsp_event_res == EVT_SLOW, rsp_filtered_bpm <= {1'b0, BRADY_HIGH} && rsp_filtered_bpm != '0)

endmodule

bind heart_rate_anomaly_detector_unit hrad_checker u_hrad_checker (.*);

`default_nettype wire
